FILE: design/vmt_pkg.sv
// shared constants for the vector move-towards datapath
`timescale 1ns / 1ps
`default_nettype none
package vmt_pkg;

  // number of vector components handled side by side
  localparam int unsigned LANES = 3;

  // divisor that turns 2^(2*frac) into the 1e-8 snap threshold
  localparam longint unsigned SNAP_DIV = 64'd100000000;

  // per-lane flag vector
  typedef logic [LANES-1:0] lane_bits_t;

endpackage
`default_nettype wire

FILE: design/vmt_if.sv
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
`default_nettype none
interface vmt_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] start_z;
  logic signed [W-1:0] goal_x;
  logic signed [W-1:0] goal_y;
  logic signed [W-1:0] goal_z;
  logic signed [W-1:0] step_dist;

  modport source (output valid, start_x, start_y, start_z, goal_x, goal_y, goal_z,
                  step_dist, input ready);
  modport sink (input valid, start_x, start_y, start_z, goal_x, goal_y, goal_z,
                step_dist, output ready);
endinterface

interface vmt_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_x;
  logic signed [W-1:0] res_y;
  logic signed [W-1:0] res_z;
  logic                arrived;

  modport source (output valid, res_x, res_y, res_z, arrived, input ready);
  modport sink (input valid, res_x, res_y, res_z, arrived, output ready);
endinterface
`default_nettype wire

FILE: design/vector_move_towards_unit.sv
// top level: move a 3d point a signed distance toward a target
//
//  channel | dir | payload
//  cmd     | in  | start_x/y/z, goal_x/y/z, step_dist
//  res     | out | res_x/y/z, arrived
//
// one request per cycle while the skid is empty
// depth set by the square root (COMP_WIDTH+1 stages) and the per-lane
// dividers (COMP_WIDTH+1 stages) that run one bit per stage
// rst is synchronous and clears vpipe, the output valid and the skid flag
// a stalled output parks the next result in the skid, freezing the pipeline
`timescale 1ns / 1ps
`default_nettype none
module vector_move_towards_unit #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  vmt_in_if.sink     cmd,
  vmt_out_if.source  res
);

  localparam int W   = COMP_WIDTH;
  localparam int R   = W + 1;
  localparam int SQW = 2 * W + 2;
  localparam int PW  = 2 * W + 1;
  localparam int N   = vmt_pkg::LANES;
  localparam int LAT = 8 + 2 * W;
  localparam longint unsigned SNAP_LIMIT =
    (64'd1 << (2 * FRAC_BITS)) / vmt_pkg::SNAP_DIV + 64'd1;
  localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};

  logic en;
  logic accept;
  logic [LAT-1:0] vpipe;

  assign accept = cmd.valid & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end

  // stage 1: capture request
  logic signed [W-1:0] s1_s [N];
  logic signed [W-1:0] s1_g [N];
  logic signed [W-1:0] s1_step;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s[0] <= cmd.start_x;
      s1_s[1] <= cmd.start_y;
      s1_s[2] <= cmd.start_z;
      s1_g[0] <= cmd.goal_x;
      s1_g[1] <= cmd.goal_y;
      s1_g[2] <= cmd.goal_z;
      s1_step <= cmd.step_dist;
    end
  end

  // stage 2: difference magnitudes and signs
  logic [W:0]          s2_magd [N];
  vmt_pkg::lane_bits_t s2_dneg;
  logic [W-1:0]        s2_magstep;
  logic                s2_stepneg;
  logic [W-1:0]        s2_s [N];
  logic [W-1:0]        s2_g [N];

  for (genvar i = 0; i < N; i++) begin : g_diff
    logic signed [W:0] d;
    assign d = {s1_g[i][W-1], s1_g[i]} - {s1_s[i][W-1], s1_s[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        s2_magd[i] <= d[W] ? (W+1)'(-d) : d;
        s2_dneg[i] <= d[W];
        s2_s[i]    <= s1_s[i];
        s2_g[i]    <= s1_g[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_magstep <= s1_step[W-1] ? W'(-s1_step) : s1_step;
      s2_stepneg <= s1_step[W-1];
    end
  end

  // stages 3-4: squares and products
  logic [SQW-1:0] sq4 [N];
  logic [PW-1:0]  prod4 [N];
  logic [2*W-1:0] stepsq4;

  for (genvar i = 0; i < N; i++) begin : g_mul
    vmt_mul #(.AW(W+1), .BW(W+1)) u_sq (
      .clk(clk), .en(en), .a(s2_magd[i]), .b(s2_magd[i]), .p(sq4[i])
    );
    vmt_mul #(.AW(W+1), .BW(W)) u_prod (
      .clk(clk), .en(en), .a(s2_magd[i]), .b(s2_magstep), .p(prod4[i])
    );
  end

  vmt_mul #(.AW(W), .BW(W)) u_stepsq (
    .clk(clk), .en(en), .a(s2_magstep), .b(s2_magstep), .p(stepsq4)
  );

  logic stepneg5;
  vmt_dly #(.WIDTH(1), .DEPTH(3)) u_dly_sn (
    .clk(clk), .en(en), .d(s2_stepneg), .q(stepneg5)
  );

  // stage 5: squared length; stage 6: snap and overshoot tests
  logic [SQW-1:0] sq5;
  logic [2*W-1:0] stepsq5;
  logic           arrived6;

  always_ff @(posedge clk) begin
    if (en) begin
      sq5      <= sq4[0] + sq4[1] + sq4[2];
      stepsq5  <= stepsq4;
      arrived6 <= (sq5 < SQW'(SNAP_LIMIT)) || (!stepneg5 && (SQW'(stepsq5) >= sq5));
    end
  end

  // square root over the next R stages
  logic [R-1:0] len;
  vmt_sqrt #(.RW(R)) u_sqrt (.clk(clk), .en(en), .x(sq5), .root(len));

  // products wait for the length, then divide per lane
  logic [N*PW-1:0] prod_dly;
  vmt_dly #(.WIDTH(N*PW), .DEPTH(R+1)) u_dly_prod (
    .clk(clk), .en(en), .d({prod4[2], prod4[1], prod4[0]}), .q(prod_dly)
  );

  logic [W-1:0] quo [N];
  for (genvar i = 0; i < N; i++) begin : g_div
    vmt_div #(.QW(W), .DW(R)) u_div (
      .clk(clk), .en(en), .num(prod_dly[i*PW +: PW]), .den(len), .quo(quo[i])
    );
  end

  // side data rides to the final stage
  localparam int SIDEW = 2 * N * W + N;
  logic [SIDEW-1:0] side_d;
  logic [SIDEW-1:0] side_q;
  logic             arrived_f;

  assign side_d = {s2_g[2], s2_g[1], s2_g[0], s2_s[2], s2_s[1], s2_s[0],
                   s2_dneg ^ {N{s2_stepneg}}};

  vmt_dly #(.WIDTH(SIDEW), .DEPTH(R+W+4)) u_dly_side (
    .clk(clk), .en(en), .d(side_d), .q(side_q)
  );
  vmt_dly #(.WIDTH(1), .DEPTH(R+W)) u_dly_arr (
    .clk(clk), .en(en), .d(arrived6), .q(arrived_f)
  );

  // final stage: signed add, saturate, pick goal when arrived
  logic [W-1:0] pres [N];
  logic         parr;

  for (genvar i = 0; i < N; i++) begin : g_fin
    logic signed [W+1:0] sext_s;
    logic signed [W+1:0] delta;
    logic signed [W+1:0] sum;
    logic [W-1:0]        sat_v;
    assign sext_s = {{2{side_q[N + i*W + W-1]}}, side_q[N + i*W +: W]};
    assign delta  = side_q[i] ? -{2'b00, quo[i]} : {2'b00, quo[i]};
    assign sum    = sext_s + delta;
    always_comb begin
      if (sum > SMAX) begin
        sat_v = SMAX[W-1:0];
      end else if (sum < SMIN) begin
        sat_v = SMIN[W-1:0];
      end else begin
        sat_v = sum[W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pres[i] <= arrived_f ? side_q[N + N*W + i*W +: W] : sat_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      parr <= arrived_f;
    end
  end

  // output register with skid
  localparam int OW = N * W + 1;
  logic          pv;
  logic [OW-1:0] pdata;
  logic          ov;
  logic [OW-1:0] odata;
  logic          skid_full;
  logic [OW-1:0] skid;

  assign pv    = vpipe[LAT-1];
  assign pdata = {pres[0], pres[1], pres[2], parr};
  assign en    = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov        <= 1'b0;
      skid_full <= 1'b0;
    end else if (!ov || res.ready) begin
      if (skid_full) begin
        odata     <= skid;
        ov        <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        odata <= pdata;
        ov    <= pv;
      end
    end else if (pv && en) begin
      skid      <= pdata;
      skid_full <= 1'b1;
    end
  end

  assign cmd.ready   = en;
  assign res.valid   = ov;
  assign res.res_x   = odata[OW-1 -: W];
  assign res.res_y   = odata[OW-1-W -: W];
  assign res.res_z   = odata[OW-1-2*W -: W];
  assign res.arrived = odata[0];

endmodule
`default_nettype wire

FILE: design/vmt_dly.sv
// enabled delay line for payload that rides along the pipeline
`timescale 1ns / 1ps
`default_nettype none
module vmt_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] stage [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      stage[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        stage[i] <= stage[i-1];
      end
    end
  end

  assign q = stage[DEPTH-1];

endmodule
`default_nettype wire

FILE: design/vmt_mul.sv
// two-stage unsigned multiplier, second operand split into halves
`timescale 1ns / 1ps
`default_nettype none
module vmt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);

  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;

  logic [AW+BL-1:0] p_lo;
  logic [AW+BH-1:0] p_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= a * b[BL-1:0];
      p_hi <= a * b[BW-1:BL];
      p    <= (AW+BW)'(p_lo) + ((AW+BW)'(p_hi) << BL);
    end
  end

endmodule
`default_nettype wire

FILE: design/vmt_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module vmt_sqrt #(
  parameter int RW = 33
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*RW-1:0] x,
  output logic      [RW-1:0]   root
);

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [2*RW-1:0] xs_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [2*RW-1:0] xs_p;
    logic [RW+1:0]   cur;
    logic [RW+1:0]   trial;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign xs_p   = x;
    end else begin : g_rest
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign xs_p   = xs_q[k-1];
    end

    // earlier remainder stays below 2^RW, so its top two bits are zero
    assign cur   = {rem_p[RW-1:0], xs_p[2*RW-1 -: 2]};
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        xs_q[k] <= xs_p << 2;
        if (cur >= trial) begin
          rem_q[k]  <= cur - trial;
          root_q[k] <= {root_p[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur;
          root_q[k] <= {root_p[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule
`default_nettype wire

FILE: design/vmt_div.sv
// pipelined restoring divider with round-half-up on the last stage
`timescale 1ns / 1ps
`default_nettype none
module vmt_div #(
  parameter int QW = 32,
  parameter int DW = 33
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [QW+DW-1:0] num,
  input  wire logic [DW-1:0]    den,
  output logic      [QW-1:0]    quo
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] nl_q  [QW];
  logic [QW-1:0] q_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] nl_p;
    logic [QW-1:0] q_p;
    logic [DW:0]   cur;

    if (k == 0) begin : g_first
      // quotient is known to fit QW bits, so the top part starts below den
      assign rem_p = num[QW+DW-1:QW];
      assign den_p = den;
      assign nl_p  = num[QW-1:0];
      assign q_p   = '0;
    end else begin : g_rest
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign nl_p  = nl_q[k-1];
      assign q_p   = q_q[k-1];
    end

    assign cur = {rem_p, nl_p[QW-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= den_p;
        nl_q[k]  <= nl_p << 1;
        if (cur >= {1'b0, den_p}) begin
          rem_q[k] <= DW'(cur - {1'b0, den_p});
          q_q[k]   <= {q_p[QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= cur[DW-1:0];
          q_q[k]   <= {q_p[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if ({rem_q[QW-1], 1'b0} >= {1'b0, den_q[QW-1]}) begin
        quo <= q_q[QW-1] + QW'(1);
      end else begin
        quo <= q_q[QW-1];
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/vmt_checker.sv
// port-level checks for the move-towards unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module vmt_checker #(
  parameter int W = 32
) (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         cmd_ready,
  input wire logic         res_valid,
  input wire logic         res_ready,
  input wire logic [W-1:0] res_x,
  input wire logic [W-1:0] res_y,
  input wire logic [W-1:0] res_z,
  input wire logic         res_arrived
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable({res_x, res_y, res_z, res_arrived}))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // request side only blocks when a result is sitting at the output
  a_block: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> res_valid)
    else $error("request blocked with no pending result");

  a_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(cmd_ready) |-> $past(res_valid && !res_ready))
    else $error("request side stalled without an output stall");

  a_keep: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready && !res_ready |=> !cmd_ready)
    else $error("request side reopened while output still stalled");

endmodule

bind vector_move_towards_unit vmt_checker #(.W(COMP_WIDTH)) u_vmt_checker (
  .clk(clk),
  .rst(rst),
  .cmd_ready(cmd.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_x(res.res_x),
  .res_y(res.res_y),
  .res_z(res.res_z),
  .res_arrived(res.arrived)
);
`default_nettype wire

FILE: verif/vector_move_towards_unit_tb.sv
// self-checking testbench for the vector move-towards unit
`timescale 1ns / 1ps
module vector_move_towards_unit_tb;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * W + 9;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1330;

  typedef struct packed {
    logic signed [W-1:0] x, y, z;
    logic                arrived;
  } point_res_t;

  typedef struct {
    logic signed [W-1:0] s [3];
    logic signed [W-1:0] g [3];
    logic signed [W-1:0] step;
  } move_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count = 0;
  int   idle_cycles = 0;
  bit   timed_out = 1'b0;

  vmt_in_if  #(.W(W)) cmd ();
  vmt_out_if #(.W(W)) res ();

  vector_move_towards_unit #(.COMP_WIDTH(W), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // integer square root, floor
  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic point_res_t predict_move(input move_req_t q);
    point_res_t         p;
    longint             d [3];
    longint             stp;
    logic [127:0]       sq;
    logic [127:0]       m;
    logic [127:0]       quo;
    logic [127:0]       rem;
    logic [63:0]        len;
    longint             v;
    logic signed [W-1:0] outv [3];
    longint             snap;
    snap = ((64'd1 << (2 * FB)) / vmt_pkg::SNAP_DIV) + 1;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(q.g[i]) - longint'(q.s[i]);
      sq += 128'(d[i] < 0 ? -d[i] : d[i]) * 128'(d[i] < 0 ? -d[i] : d[i]);
    end
    stp = longint'(q.step);
    if (sq < 128'(snap) || (stp >= 0 && sq <= 128'(stp) * 128'(stp))) begin
      p.x = q.g[0]; p.y = q.g[1]; p.z = q.g[2]; p.arrived = 1'b1;
      return p;
    end
    len = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      m = 128'(d[i] < 0 ? -d[i] : d[i]) * 128'(stp < 0 ? -stp : stp);
      quo = m / 128'(len);
      rem = m % 128'(len);
      if (rem >= 128'(len) - rem) quo++;
      v = ((d[i] < 0) != (stp < 0)) ? -longint'(quo) : longint'(quo);
      v = longint'(q.s[i]) + v;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      outv[i] = v[W-1:0];
    end
    p.x = outv[0]; p.y = outv[1]; p.z = outv[2]; p.arrived = 1'b0;
    return p;
  endfunction

  class move_scoreboard;
    point_res_t pending [$];

    function void note_request(move_req_t q);
      pending.push_back(predict_move(q));
    endfunction

    task check_result(point_res_t got);
      point_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.x, '0);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report_mismatch("res_x", got.x, want.x);
      if (got.y !== want.y) report_mismatch("res_y", got.y, want.y);
      if (got.z !== want.z) report_mismatch("res_z", got.z, want.z);
      if (got.arrived !== want.arrived)
        report_mismatch("arrived", W'(got.arrived), W'(want.arrived));
    endtask
  endclass

  move_scoreboard sb = new();
  move_req_t      cur_req;
  bit             stall_mode = 1'b0;

  // input side: sample request handshake
  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready) begin
      cur_req.s[0] = cmd.start_x; cur_req.s[1] = cmd.start_y;
      cur_req.s[2] = cmd.start_z; cur_req.g[0] = cmd.goal_x;
      cur_req.g[1] = cmd.goal_y;  cur_req.g[2] = cmd.goal_z;
      cur_req.step = cmd.step_dist;
      sb.note_request(cur_req);
    end
  end

  // output side: check results, watchdog
  always @(posedge clk) begin
    point_res_t got;
    if (!rst && res.valid && res.ready) begin
      got.x = res.res_x; got.y = res.res_y; got.z = res.res_z;
      got.arrived = res.arrived;
      sb.check_result(got);
    end
    if (!rst && !(cmd.valid && cmd.ready) && !(res.valid && res.ready)) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("Some tests failed");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // receiver stall pattern: phases of free flow and of random back-pressure
  int stall_phase = 0;
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      stall_phase++;
      if (stall_phase % 300 == 0) stall_mode = ~stall_mode;
      if (!stall_mode) res.ready <= 1'b1;
      else res.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 17 < 12);
    end
  end

  function automatic logic signed [W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return W'($urandom_range(0, 64)) - 32;
      3: return $signed($urandom) >>> $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  // drives one request and holds it until accepted
  task automatic send_move(input move_req_t q);
    cmd.valid <= 1'b1;
    cmd.start_x <= q.s[0]; cmd.start_y <= q.s[1]; cmd.start_z <= q.s[2];
    cmd.goal_x <= q.g[0];  cmd.goal_y <= q.g[1];  cmd.goal_z <= q.g[2];
    cmd.step_dist <= q.step;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
  endtask

  task automatic make_move(input logic signed [W-1:0] sx, sy, sz, gx, gy, gz, st);
    move_req_t q;
    q.s[0] = sx; q.s[1] = sy; q.s[2] = sz;
    q.g[0] = gx; q.g[1] = gy; q.g[2] = gz;
    q.step = st;
    send_move(q);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  move_req_t rq;
  int        burst;
  int        sent;
  int        gap;
  int        mode;

  initial begin
    cmd.valid = 1'b0;
    cmd.start_x = '0; cmd.start_y = '0; cmd.start_z = '0;
    cmd.goal_x = '0;  cmd.goal_y = '0;  cmd.goal_z = '0;
    cmd.step_dist = '0;
    res.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero length, snap edge, overshoot, partial, negative, extremes
    make_move(0, 0, 0, 0, 0, 0, 0);
    make_move(0, 0, 0, 6, 1, 1, 0);     // sq 38, snaps
    make_move(0, 0, 0, 6, 2, 1, 0);     // sq 41, snaps
    make_move(0, 0, 0, 5, 4, 1, 0);     // sq 42, snaps
    make_move(0, 0, 0, 5, 4, 2, 0);     // sq 45, no snap
    make_move(0, 0, 0, 32'sh10000, 0, 0, 32'sh10000);   // exact reach
    make_move(0, 0, 0, 32'sh10000, 0, 0, 32'sh0ffff);   // just short
    make_move(0, 0, 0, 32'sh30000, 32'sh40000, 0, 32'sh10000);
    make_move(0, 0, 0, 32'sh30000, 32'sh40000, 0, -32'sh10000);
    make_move(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh00000001);
    make_move(32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    make_move(32'sh7fffffff, 0, 32'sh80000000,
              32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000);
    make_move(32'sh7ff00000, 0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000);
    make_move(32'sh80100000, 0, 0, 32'sh80000000, 0, 0, 32'sh80000000);
    make_move(0, 0, 0, 3, 0, 0, 1);     // sq 9, snaps
    make_move(5, -7, 9, -3, 11, 2, 3);
    make_move(-1, -1, -1, 1, 1, 1, 32'sh7fffffff);
    make_move(32'sh12345678, 32'shedcba987, 32'sh0, 32'sh0, 0, 32'sh7fffffff, -1);
    // sender waits until every expected result is back
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        for (int k = 0; k < 3; k++) begin
          rq.s[k] = rand_comp();
          mode = $urandom_range(0, 3);
          if (mode == 0) rq.g[k] = rq.s[k] + W'($urandom_range(0, 8)) - 4;
          else rq.g[k] = rand_comp();
        end
        case ($urandom_range(0, 3))
          0: rq.step = rand_comp();
          1: rq.step = W'($urandom_range(0, 32'h0010_0000));
          2: rq.step = -W'($urandom_range(0, 32'h0010_0000));
          default: rq.step = $urandom;
        endcase
        send_move(rq);
        sent++;
      end
      cmd.valid <= 1'b0;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      repeat (gap) @(negedge clk);
      if (sent > 600 && sent < 650) drain();
    end

    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
